// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros: clocked implication checks with synchronous
// active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define DQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg
// Types and codes shared by the double-ended queue controller and datapath.
// ---------------------------------------------------------------------------
package dq_pkg;

    // Operation codes carried on the input tuser
    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_REAR  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_REAR   = 3'd3,
        FN_LIST_ALL   = 3'd4
    } t_func;

    // Result kinds carried on the output tuser
    typedef enum logic [2:0] {
        KD_POP   = 3'd0,
        KD_ELEM  = 3'd1,
        KD_EMPTY = 3'd2,
        KD_UNDER = 3'd3,
        KD_OVER  = 3'd4
    } t_kind;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_LIST,
        ST_STAT
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic  push_front;
        logic  push_rear;
        logic  pop_front;
        logic  pop_rear;
        logic  list_start;
        logic  list_next;
        logic  load_out;
        logic  out_from_mem;
        logic  out_last;
        t_kind out_kind;
    } t_dq_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
        logic out_free;
    } t_dq_stat;

endpackage

// ===== rtl/core/dq_dpath.sv =====
// ---------------------------------------------------------------------------
// dq_dpath
// Ring-buffer storage, head/count pointers, listing cursor and the output
// register of the double-ended queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_dpath #(
    parameter int DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dq_pkg::t_dq_cmd i_cmd,
    output dq_pkg::t_dq_stat o_stat,
    input  logic [31:0]     i_item_value,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [2:0]      o_out_kind,
    output logic [31:0]     o_out_value,
    output logic            o_out_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    // Ring position helpers
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    // base + off, with off below DEPTH, folded back into the ring
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_data;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_lptr, n_lptr;
    logic [AW-1:0] r_idx, n_idx;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;

    logic          r_out_valid;
    logic [2:0]    r_out_kind;
    logic [31:0]   r_out_value;
    logic          r_out_last;

    // Pointer update and memory port control
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_lptr  = r_lptr;
        n_idx   = r_idx;
        rd_en   = 1'b0;
        rd_addr = r_head;
        wr_en   = 1'b0;
        wr_addr = r_head;
        if (i_cmd.push_front) begin
            wr_en   = 1'b1;
            wr_addr = ptr_dec(r_head);
            n_head  = ptr_dec(r_head);
            n_count = r_count + CW'(1);
        end
        if (i_cmd.push_rear) begin
            wr_en   = 1'b1;
            wr_addr = ptr_add(r_head, r_count);
            n_count = r_count + CW'(1);
        end
        if (i_cmd.pop_front) begin
            rd_en   = 1'b1;
            rd_addr = r_head;
            n_head  = ptr_inc(r_head);
            n_count = r_count - CW'(1);
        end
        if (i_cmd.pop_rear) begin
            rd_en   = 1'b1;
            rd_addr = ptr_add(r_head, r_count - CW'(1));
            n_count = r_count - CW'(1);
        end
        if (i_cmd.list_start) begin
            rd_en   = 1'b1;
            rd_addr = r_head;
            n_lptr  = ptr_inc(r_head);
            n_idx   = '0;
        end
        if (i_cmd.list_next) begin
            rd_en   = 1'b1;
            rd_addr = r_lptr;
            n_lptr  = ptr_inc(r_lptr);
            n_idx   = r_idx + AW'(1);
        end
    end

    // Pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_lptr  <= '0;
            r_idx   <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_lptr  <= n_lptr;
            r_idx   <= n_idx;
        end
    end

    // Entry storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_item_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_kind  <= i_cmd.out_kind;
            r_out_value <= i_cmd.out_from_mem ? r_rd_data : 32'd0;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.list_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

    // Checks
    `DQ_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "fill count beyond depth")
    `DQ_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_cmd.push_front || i_cmd.push_rear, !o_stat.full, "push into full queue")
    `DQ_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_cmd.load_out, o_stat.out_free, "output register overwritten")
    `DQ_ASSERT_NXT(a_pop_shrinks, i_clk, i_rst_n, (i_cmd.pop_front || i_cmd.pop_rear) && !o_stat.empty, r_count + CW'(1) == $past(r_count), "pop did not shrink queue")

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// ---------------------------------------------------------------------------
// dq_ctrl
// Operation sequencer: decodes each input transfer and steps the datapath
// through push, pop, listing and status results.
// ---------------------------------------------------------------------------
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_func,
    input  dq_pkg::t_dq_stat i_stat,
    output dq_pkg::t_dq_cmd  o_cmd
);

    dq_pkg::t_state r_state, n_state;
    dq_pkg::t_kind  r_kind, n_kind;
    dq_pkg::t_func  func;
    logic           accept;

    assign func   = dq_pkg::t_func'(i_func);
    assign accept = i_in_valid && o_in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::ST_IDLE;
            r_kind  <= dq_pkg::KD_UNDER;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    case (func)
                        dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_REAR: begin
                            if (i_stat.full) begin
                                n_kind  = dq_pkg::KD_OVER;
                                n_state = dq_pkg::ST_STAT;
                            end else begin
                                o_cmd.push_front = (func == dq_pkg::FN_PUSH_FRONT);
                                o_cmd.push_rear  = (func == dq_pkg::FN_PUSH_REAR);
                            end
                        end
                        dq_pkg::FN_POP_FRONT, dq_pkg::FN_POP_REAR: begin
                            if (i_stat.empty) begin
                                n_kind  = dq_pkg::KD_UNDER;
                                n_state = dq_pkg::ST_STAT;
                            end else begin
                                o_cmd.pop_front = (func == dq_pkg::FN_POP_FRONT);
                                o_cmd.pop_rear  = (func == dq_pkg::FN_POP_REAR);
                                n_state         = dq_pkg::ST_POP;
                            end
                        end
                        dq_pkg::FN_LIST_ALL: begin
                            if (i_stat.empty) begin
                                n_kind  = dq_pkg::KD_EMPTY;
                                n_state = dq_pkg::ST_STAT;
                            end else begin
                                o_cmd.list_start = 1'b1;
                                n_state          = dq_pkg::ST_LIST;
                            end
                        end
                        default: begin
                            // unused codes: dropped
                        end
                    endcase
                end
            end
            dq_pkg::ST_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out     = 1'b1;
                    o_cmd.out_from_mem = 1'b1;
                    o_cmd.out_last     = 1'b1;
                    o_cmd.out_kind     = dq_pkg::KD_POP;
                    n_state            = dq_pkg::ST_IDLE;
                end
            end
            dq_pkg::ST_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out     = 1'b1;
                    o_cmd.out_from_mem = 1'b1;
                    o_cmd.out_last     = i_stat.list_last;
                    o_cmd.out_kind     = dq_pkg::KD_ELEM;
                    if (i_stat.list_last) begin
                        n_state = dq_pkg::ST_IDLE;
                    end else begin
                        o_cmd.list_next = 1'b1;
                    end
                end
            end
            dq_pkg::ST_STAT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.out_kind = r_kind;
                    n_state        = dq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/double_ended_queue_top.sv =====
// ---------------------------------------------------------------------------
// Channel  Dir  tdata                 tuser                tlast
// s_axis   in   [31:0] item_value     [2:0] func           -
// m_axis   out  [31:0] result_value   [2:0] result_kind    last_of_run
//
// Push: no result. Pop: the registered memory read, then the output load.
// Overflow, underflow, empty listing: decode, then status load.
// Listing: one element per cycle via the read port while the output frees.
// A waiting result stays in the output register and the next item is taken;
// a later pop, listing or status result stalls until that register frees.
// Synchronous active-low reset empties the queue; stored words are not cleared.
// ---------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of 32-bit words held in a ring buffer.
// ---------------------------------------------------------------------------
module double_ended_queue_top #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
    output logic        m_axis_tlast
);

    dq_pkg::t_dq_cmd  cmd;
    dq_pkg::t_dq_stat stat;

    // Sequencer
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage and output register
    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_item_value (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_kind   (m_axis_tuser),
        .o_out_value  (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for double_ended_queue_top. A directed table covers
// empty-queue errors, unused operation codes and extreme words; a random
// phase then alternates fill, drain and mixed traffic so the ring wraps,
// fills to overflow and drains to underflow. A shadow deque predicts every
// result not typed in the table, and each output transfer is compared field by field, in order.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH      = 32;
    localparam int RAND_ITEMS = 400;

    // Operation codes the block ignores
    localparam logic [2:0] FN_UNUSED_LO  = 3'd5;
    localparam logic [2:0] FN_UNUSED_MID = 3'd6;
    localparam logic [2:0] FN_UNUSED_HI  = 3'd7;

    // Traffic mixes for the random phase
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    typedef struct {
        dq_pkg::t_kind kind;
        logic [31:0]   value;
        logic          last;
    } t_result;

    typedef struct {
        logic [2:0]    fn;
        logic [31:0]   word;
        bit            typed;
        dq_pkg::t_kind kind;
        logic [31:0]   res;
    } t_op_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] item_value
    logic [2:0]  s_axis_tuser;   // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // [31:0] result_value
    logic [2:0]  m_axis_tuser;   // [2:0] result_kind
    logic        m_axis_tlast;

    // Hand-written expectation riding along with the current item
    bit            row_typed;
    dq_pkg::t_kind row_kind;
    logic [31:0]   row_res;

    // Shadow deque
    logic [31:0] shadow_mem [DEPTH];
    int          shadow_head;
    int          shadow_count;

    t_result     awaited_results[$];
    int          errors;
    int          burst_left;

    // Directed table: typed results only where obvious
    t_op_row dir_rows [0:20] = '{
        '{dq_pkg::FN_POP_FRONT,  32'h0000_0000, 1'b1, dq_pkg::KD_UNDER, 32'h0},
        '{dq_pkg::FN_POP_REAR,   32'hFFFF_FFFF, 1'b1, dq_pkg::KD_UNDER, 32'h0},
        '{dq_pkg::FN_LIST_ALL,   32'h1234_5678, 1'b1, dq_pkg::KD_EMPTY, 32'h0},
        '{FN_UNUSED_LO,          32'hDEAD_BEEF, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{FN_UNUSED_MID,         32'hFFFF_FFFF, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{FN_UNUSED_HI,          32'h8000_0000, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_PUSH_REAR,  32'h8000_0000, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_PUSH_REAR,  32'h0000_0000, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_LIST_ALL,   32'h0,         1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_POP_FRONT,  32'h0,         1'b1, dq_pkg::KD_POP,   32'hFFFF_FFFF},
        '{dq_pkg::FN_POP_REAR,   32'h0,         1'b1, dq_pkg::KD_POP,   32'h0000_0000},
        '{dq_pkg::FN_LIST_ALL,   32'h0,         1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_POP_REAR,   32'h0,         1'b1, dq_pkg::KD_POP,   32'h8000_0000},
        '{dq_pkg::FN_POP_FRONT,  32'h0,         1'b1, dq_pkg::KD_POP,   32'h7FFF_FFFF},
        '{dq_pkg::FN_POP_REAR,   32'h0,         1'b1, dq_pkg::KD_UNDER, 32'h0},
        '{dq_pkg::FN_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_PUSH_FRONT, 32'h5555_5555, 1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_POP_REAR,   32'h0,         1'b0, dq_pkg::KD_POP,   32'h0},
        '{dq_pkg::FN_LIST_ALL,   32'h0,         1'b0, dq_pkg::KD_POP,   32'h0}
    };

    double_ended_queue_top #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Record one predicted result
    task automatic note_result(input dq_pkg::t_kind kind, input logic [31:0] value,
                               input logic last, input bit record);
        t_result r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        if (record) awaited_results.push_back(r);
    endtask

    // Shadow deque: apply one operation, queue what it produces
    task automatic apply_deque_op(input logic [2:0] fn, input logic [31:0] word,
                                  input bit record);
        int pos;
        case (fn)
            dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_REAR: begin
                if (shadow_count >= DEPTH) begin
                    note_result(dq_pkg::KD_OVER, 32'h0, 1'b1, record);
                end else if (fn == dq_pkg::FN_PUSH_FRONT) begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_mem[shadow_head] = word;
                    shadow_count++;
                end else begin
                    shadow_mem[(shadow_head + shadow_count) % DEPTH] = word;
                    shadow_count++;
                end
            end
            dq_pkg::FN_POP_FRONT, dq_pkg::FN_POP_REAR: begin
                if (shadow_count == 0) begin
                    note_result(dq_pkg::KD_UNDER, 32'h0, 1'b1, record);
                end else if (fn == dq_pkg::FN_POP_FRONT) begin
                    pos = shadow_head;
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                    note_result(dq_pkg::KD_POP, shadow_mem[pos], 1'b1, record);
                end else begin
                    pos = (shadow_head + shadow_count - 1) % DEPTH;
                    shadow_count--;
                    note_result(dq_pkg::KD_POP, shadow_mem[pos], 1'b1, record);
                end
            end
            dq_pkg::FN_LIST_ALL: begin
                if (shadow_count == 0) begin
                    note_result(dq_pkg::KD_EMPTY, 32'h0, 1'b1, record);
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        note_result(dq_pkg::KD_ELEM,
                                    shadow_mem[(shadow_head + i) % DEPTH],
                                    i + 1 == shadow_count, record);
                end
            end
            default: ;  // unused codes: no result, no change
        endcase
    endtask

    // Output check and input prediction, both on the rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result transfer: kind %0d value %h last %0b",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("result_kind: expected %0d, actual %0d",
                               want.kind, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata !== want.value) begin
                        $error("result_value: expected %h, actual %h",
                               want.value, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_deque_op(s_axis_tuser, s_axis_tdata, !row_typed);
                if (row_typed) note_result(row_kind, row_res, 1'b1, 1'b1);
            end
        end
    end

    // Receiver: stall pattern switching between several modes
    always @(negedge i_clk) begin
        static int mode      = 0;
        static int mode_left = 0;
        static int stall     = 0;
        static int tick      = 0;
        if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 200);
        end else begin
            mode_left--;
        end
        tick++;
        case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (tick % 3 == 0);
            default: begin
                if (stall != 0) begin
                    stall--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall = $urandom_range(1, 20);
                end
            end
        endcase
    end

    // Drive one item and hold it until the transfer
    task automatic send_op(input logic [2:0] fn, input logic [31:0] word,
                           input bit typed, input dq_pkg::t_kind kind,
                           input logic [31:0] res);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= word;
        row_typed     <= typed;
        row_kind      <= kind;
        row_res       <= res;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Sender idles with valid low and junk on the bus
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            s_axis_tuser  <= 3'($urandom_range(0, 7));
        end
    endtask

    // Bursts of random length with random gaps, sometimes long gap-free runs
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_cycles($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Weighted operation choice per traffic mix
    function automatic logic [2:0] pick_func(input t_mix mix);
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        push_pct = (mix == MIX_FILL) ? 82 : (mix == MIX_DRAIN) ? 10 : 44;
        if (r < 3) return 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        if (r < 11) return dq_pkg::FN_LIST_ALL;
        if (r < 11 + push_pct)
            return $urandom_range(0, 1) ? dq_pkg::FN_PUSH_FRONT : dq_pkg::FN_PUSH_REAR;
        return $urandom_range(0, 1) ? dq_pkg::FN_POP_FRONT : dq_pkg::FN_POP_REAR;
    endfunction

    // Stimulus
    initial begin
        int          counted;
        int          mix_left;
        t_mix        mix;
        logic [2:0]  fn;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'h0;
        s_axis_tuser  = 3'd0;
        row_typed     = 1'b0;
        row_kind      = dq_pkg::KD_POP;
        row_res       = 32'h0;
        shadow_head   = 0;
        shadow_count  = 0;
        errors        = 0;
        burst_left    = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (dir_rows[i]) begin
            send_op(dir_rows[i].fn, dir_rows[i].word, dir_rows[i].typed,
                    dir_rows[i].kind, dir_rows[i].res);
            pace();
        end

        // Random traffic in alternating mixes
        counted  = 0;
        mix      = MIX_FILL;
        mix_left = $urandom_range(45, 70);
        while (counted < RAND_ITEMS) begin
            if (mix_left == 0) begin
                mix      = (mix == MIX_FILL) ? MIX_EVEN :
                           (mix == MIX_EVEN) ? MIX_DRAIN : MIX_FILL;
                mix_left = $urandom_range(45, 70);
            end
            fn = pick_func(mix);
            send_op(fn, pick_word(), 1'b0, dq_pkg::KD_POP, 32'h0);
            if (fn <= dq_pkg::FN_LIST_ALL) begin
                counted++;
                mix_left--;
            end
            pace();
        end
        idle_cycles(1);

        // Drain, then allow for stragglers
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dq_pkg.sv
rtl/core/dq_dpath.sv
rtl/core/dq_ctrl.sv
rtl/core/double_ended_queue_top.sv
tb/tb_top.sv
